>>> src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define WPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included
`define WPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/wpc_pkg.sv
// Types and constants of the weighted port chooser.
`timescale 1ns / 1ps

package wpc_pkg;

  // Port slots: configured count, clipped to the slots the registers describe
  localparam int NUM_PORTS = 4;
  localparam int SLOT_REGS = 4;
  localparam int NUM_SLOTS = (NUM_PORTS < SLOT_REGS) ? NUM_PORTS : SLOT_REGS;

  // Field and datapath widths
  localparam int INC_W  = 3;
  localparam int SLOT_W = 2;
  localparam int RND_W  = 16;
  localparam int WGT_W  = 8;
  localparam int SUM_W  = 10;  // up to four weights of 255
  localparam int CNT_W  = 3;   // up to four candidates
  localparam int NUM_CELLS = RND_W;  // one dividend bit per cell
  localparam int LATENCY   = NUM_CELLS + 1;

  // Incoming code for an item with no incoming port
  localparam logic [INC_W-1:0] NO_INC = 3'd4;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESENT = 3'd1;
  localparam logic [IDX_W-1:0] REG_IDS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_W_IN0   = 3'd3;
  localparam logic [IDX_W-1:0] REG_W_IN1   = 3'd4;
  localparam logic [IDX_W-1:0] REG_W_IN2   = 3'd5;
  localparam logic [IDX_W-1:0] REG_W_IN3   = 3'd6;
  localparam logic [IDX_W-1:0] REG_W_NO_IN = 3'd7;

  // Input item
  typedef struct packed {
    logic [INC_W-1:0] incoming_slot;
    logic             allow_bounce;
    logic             force_bounce;
    logic [RND_W-1:0] rnd;
  } in_t;

  // Result item
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] out_slot;
    logic              used_fallback;
  } res_t;

  // Configuration registers; wgt[4] is the no-incoming-port set
  typedef struct packed {
    logic                           mode;
    logic [SLOT_REGS-1:0]           present;
    logic [DATA_W-1:0]              ids;
    logic [SLOT_REGS:0][DATA_W-1:0] wgt;
  } cfg_t;

  // Decisions made at the front, carried along the cell row
  typedef struct packed {
    logic                 mode;
    logic                 det_found;
    logic [SLOT_W-1:0]    det_slot;
    logic [SLOT_REGS-1:0] elig;
    logic [DATA_W-1:0]    wgt;
    logic [SLOT_REGS-1:0] cand;
    logic [SUM_W-1:0]     sum;
    logic [CNT_W-1:0]     cnt;
  } side_t;

  // One stage of the remainder chain
  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [SUM_W-1:0] rem_w;
    logic [CNT_W-1:0] rem_c;
    logic [RND_W-1:0] dvd;
  } stage_t;

endpackage

>>> src/weighted_port_chooser.sv
// Top level of the weighted port chooser: register port and the cell row.
`timescale 1ns / 1ps
// Weighted port chooser.
// Picks an outgoing port slot for an item that arrives on slot 0..3 or on no
// port (code 4 and above). Input: start with in_i; an item is accepted at a
// rising edge with start high and busy low. busy stays low, so an item may be
// accepted in every cycle. Output: done_o marks res_o for exactly one cycle;
// the receiver cannot stall, so results simply leave as they come.
// An item passes through the front stage, the sixteen remainder cells and
// the result register. Throughput: one item per cycle. The row holds
// sixteen cells, each taking one bit of rnd through a restoring remainder
// step for both the weight sum and the candidate count. Configuration: APB
// registers at byte addresses 0,4,..,28 (mode, present mask, port ids, five
// weight sets); the user writes them only while the block is idle, and the
// block itself does not enforce this. Reset clears the configuration
// registers and the valid flags of in-flight items; no result follows an
// item that was still in the row when reset came.

module weighted_port_chooser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  wpc_pkg::in_t                  in_i,
  output logic                          done_o,
  output wpc_pkg::res_t                 res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [wpc_pkg::DATA_W-1:0]    pwdata,
  output logic [wpc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  wpc_pkg::cfg_t              cfg_q;
  logic [wpc_pkg::IDX_W-1:0]  idx;
  logic                       wr_en;
  logic                       accept;
  wpc_pkg::stage_t            chain [wpc_pkg::NUM_CELLS+1];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign idx    = paddr[wpc_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        wpc_pkg::REG_MODE:    cfg_q.mode    <= pwdata[0];
        wpc_pkg::REG_PRESENT: cfg_q.present <= pwdata[wpc_pkg::SLOT_REGS-1:0];
        wpc_pkg::REG_IDS:     cfg_q.ids     <= pwdata;
        wpc_pkg::REG_W_IN0:   cfg_q.wgt[0]  <= pwdata;
        wpc_pkg::REG_W_IN1:   cfg_q.wgt[1]  <= pwdata;
        wpc_pkg::REG_W_IN2:   cfg_q.wgt[2]  <= pwdata;
        wpc_pkg::REG_W_IN3:   cfg_q.wgt[3]  <= pwdata;
        wpc_pkg::REG_W_NO_IN: cfg_q.wgt[4]  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (idx)
      wpc_pkg::REG_MODE:    prdata = wpc_pkg::DATA_W'(cfg_q.mode);
      wpc_pkg::REG_PRESENT: prdata = wpc_pkg::DATA_W'(cfg_q.present);
      wpc_pkg::REG_IDS:     prdata = cfg_q.ids;
      wpc_pkg::REG_W_IN0:   prdata = cfg_q.wgt[0];
      wpc_pkg::REG_W_IN1:   prdata = cfg_q.wgt[1];
      wpc_pkg::REG_W_IN2:   prdata = cfg_q.wgt[2];
      wpc_pkg::REG_W_IN3:   prdata = cfg_q.wgt[3];
      wpc_pkg::REG_W_NO_IN: prdata = cfg_q.wgt[4];
      default:              prdata = '0;
    endcase
  end

  // Front stage
  wpc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .stage_o  (chain[0])
  );

  // Row of remainder cells, most significant rnd bit first
  for (genvar k = 0; k < wpc_pkg::NUM_CELLS; k++) begin : g_cell
    wpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  // Result selection and output register
  wpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (chain[wpc_pkg::NUM_CELLS]),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

>>> src/wpc_front.sv
// Front stage: slot masks, weight sum, deterministic pick and candidate count.
`timescale 1ns / 1ps

module wpc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  wpc_pkg::in_t    in_i,
  input  wpc_pkg::cfg_t   cfg_i,
  output wpc_pkg::stage_t stage_o
);

  logic [wpc_pkg::INC_W-1:0]     inc;
  logic [wpc_pkg::DATA_W-1:0]    wreg;
  logic [wpc_pkg::SLOT_REGS-1:0] pres;
  logic [wpc_pkg::WGT_W-1:0]     best;
  logic [wpc_pkg::WGT_W-1:0]     w;
  wpc_pkg::stage_t               stage_d;
  logic                          valid_q;
  wpc_pkg::stage_t               stage_q;

  // Decode the item against the configuration
  always_comb begin
    stage_d = '0;
    best    = '0;
    w       = '0;
    inc     = (in_i.incoming_slot > wpc_pkg::NO_INC) ? wpc_pkg::NO_INC : in_i.incoming_slot;
    wreg    = cfg_i.wgt[inc];
    for (int i = 0; i < wpc_pkg::SLOT_REGS; i++) begin
      pres[i]              = cfg_i.present[i] && (i < wpc_pkg::NUM_SLOTS);
      stage_d.side.elig[i] = pres[i] && (inc != wpc_pkg::INC_W'(i));
    end

    // weight sum over eligible slots
    for (int i = 0; i < wpc_pkg::SLOT_REGS; i++) begin
      if (stage_d.side.elig[i]) begin
        stage_d.side.sum = stage_d.side.sum +
                           wpc_pkg::SUM_W'(wreg[wpc_pkg::WGT_W*i +: wpc_pkg::WGT_W]);
      end
    end

    // highest weight, lower id on a tie, lower slot on equal ids
    for (int i = 0; i < wpc_pkg::SLOT_REGS; i++) begin
      w = wreg[wpc_pkg::WGT_W*i +: wpc_pkg::WGT_W];
      if (stage_d.side.elig[i]) begin
        if (!stage_d.side.det_found || (w > best) ||
            ((w == best) && (cfg_i.ids[wpc_pkg::WGT_W*i +: wpc_pkg::WGT_W] <
                             cfg_i.ids[wpc_pkg::WGT_W*stage_d.side.det_slot +: wpc_pkg::WGT_W])))
        begin
          best                  = w;
          stage_d.side.det_slot = wpc_pkg::SLOT_W'(i);
          stage_d.side.det_found = 1'b1;
        end
      end
    end

    // uniform fallback candidates
    for (int i = 0; i < wpc_pkg::SLOT_REGS; i++) begin
      if (!in_i.allow_bounce && in_i.force_bounce) begin
        stage_d.side.cand[i] = pres[i] && (inc == wpc_pkg::INC_W'(i));
      end else begin
        stage_d.side.cand[i] = stage_d.side.elig[i];
      end
      stage_d.side.cnt = stage_d.side.cnt + wpc_pkg::CNT_W'(stage_d.side.cand[i]);
    end

    stage_d.side.mode = cfg_i.mode;
    stage_d.side.wgt  = wreg;
    stage_d.valid     = accept_i;
    stage_d.rem_w     = '0;
    stage_d.rem_c     = '0;
    stage_d.dvd       = in_i.rnd;
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

>>> src/wpc_cell.sv
// One remainder cell: a restoring step for the weight sum and the candidate count.
`timescale 1ns / 1ps

module wpc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wpc_pkg::stage_t stage_i,
  output wpc_pkg::stage_t stage_o
);

  logic [wpc_pkg::SUM_W:0] shift_w;
  logic [wpc_pkg::CNT_W:0] shift_c;
  wpc_pkg::stage_t         stage_d;
  logic                    valid_q;
  wpc_pkg::stage_t         stage_q;

  // Bring in the next dividend bit, subtract where the divisor fits
  always_comb begin
    stage_d = stage_i;
    shift_w = {stage_i.rem_w, stage_i.dvd[wpc_pkg::RND_W-1]};
    shift_c = {stage_i.rem_c, stage_i.dvd[wpc_pkg::RND_W-1]};
    if (shift_w >= {1'b0, stage_i.side.sum}) begin
      stage_d.rem_w = wpc_pkg::SUM_W'(shift_w - {1'b0, stage_i.side.sum});
    end else begin
      stage_d.rem_w = shift_w[wpc_pkg::SUM_W-1:0];
    end
    if (shift_c >= {1'b0, stage_i.side.cnt}) begin
      stage_d.rem_c = wpc_pkg::CNT_W'(shift_c - {1'b0, stage_i.side.cnt});
    end else begin
      stage_d.rem_c = shift_c[wpc_pkg::CNT_W-1:0];
    end
    stage_d.dvd = {stage_i.dvd[wpc_pkg::RND_W-2:0], 1'b0};
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

>>> src/wpc_back.sv
// Back stage: cumulative weight walk, uniform pick and the result register.
`timescale 1ns / 1ps

module wpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wpc_pkg::stage_t stage_i,
  output logic            done_o,
  output wpc_pkg::res_t   res_o
);

  logic [wpc_pkg::SUM_W-1:0]  cum;
  logic                       walk_found;
  logic [wpc_pkg::SLOT_W-1:0] walk_slot;
  logic [wpc_pkg::CNT_W-1:0]  seen;
  logic                       uni_found;
  logic [wpc_pkg::SLOT_W-1:0] uni_slot;
  wpc_pkg::res_t              res_d;
  logic                       done_q;
  wpc_pkg::res_t              res_q;

  // Walk the cumulative weights of eligible slots
  always_comb begin
    cum        = '0;
    walk_found = 1'b0;
    walk_slot  = '0;
    for (int i = 0; i < wpc_pkg::SLOT_REGS; i++) begin
      if (!walk_found && stage_i.side.elig[i]) begin
        cum = cum + wpc_pkg::SUM_W'(stage_i.side.wgt[wpc_pkg::WGT_W*i +: wpc_pkg::WGT_W]);
        if (stage_i.rem_w < cum) begin
          walk_found = 1'b1;
          walk_slot  = wpc_pkg::SLOT_W'(i);
        end
      end
    end
  end

  // Candidate number rem_c among the fallback candidates
  always_comb begin
    seen      = '0;
    uni_found = 1'b0;
    uni_slot  = '0;
    for (int i = 0; i < wpc_pkg::SLOT_REGS; i++) begin
      if (!uni_found && stage_i.side.cand[i]) begin
        if (seen == stage_i.rem_c) begin
          uni_found = 1'b1;
          uni_slot  = wpc_pkg::SLOT_W'(i);
        end
        seen = seen + wpc_pkg::CNT_W'(1);
      end
    end
  end

  // Pick the result
  always_comb begin
    res_d = '0;
    if (stage_i.side.mode && stage_i.side.det_found) begin
      res_d.found    = 1'b1;
      res_d.out_slot = stage_i.side.det_slot;
    end else if (!stage_i.side.mode && (stage_i.side.sum != '0) && walk_found) begin
      res_d.found    = 1'b1;
      res_d.out_slot = walk_slot;
    end else if ((stage_i.side.cnt != '0) && uni_found) begin
      res_d.found         = 1'b1;
      res_d.out_slot      = uni_slot;
      res_d.used_fallback = 1'b1;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_i.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/wpc_checker.sv
// Port-level checks of the weighted port chooser and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wpc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_i,
  input logic          done_i,
  input wpc_pkg::res_t res_i
);

  // A result strobe only follows an accepted item
  `WPC_ASSERT(a_done_follows_item, done_i |-> $past(start_i && !busy_i, wpc_pkg::LATENCY + 1), "result without an accepted item")

  // No port chosen leaves slot and fallback flag clear
  `WPC_ASSERT(a_none_is_clear, (done_i && !res_i.found) |-> ((res_i.out_slot == '0) && !res_i.used_fallback), "empty result not cleared")

  // The fallback flag only comes with a chosen port
  `WPC_ASSERT(a_fallback_found, (done_i && res_i.used_fallback) |-> res_i.found, "fallback without a chosen port")

  // No result strobe while in reset
  `WPC_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !done_i, "result strobe during reset")

endmodule

bind weighted_port_chooser wpc_checker u_wpc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o),
  .res_i   (res_o)
);
